// File: src/secmc_pkg.sv
package secmc_pkg;

  // width of the millisecond time base; differences wrap at this width
  localparam int TIME_W = 32;

  localparam int VOLT_W  = 14;
  localparam int IVAL_W  = 16;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 16;
  localparam int MODE_W  = 3;
  localparam int MOTOR_W = 2;
  localparam int LED_W   = 8;
  localparam int LEVEL_W = 7;

  // one-hot internal mode register
  typedef enum logic [6:0] {
    MODE_CHARGING = 7'b0000001,
    MODE_WAKEUP   = 7'b0000010,
    MODE_READY    = 7'b0000100,
    MODE_TURBO    = 7'b0001000,
    MODE_ECO      = 7'b0010000,
    MODE_SURVIVAL = 7'b0100000,
    MODE_SLEEP    = 7'b1000000
  } mode_t;

  // external mode codes
  localparam logic [MODE_W-1:0] CODE_CHARGING = 3'd0;
  localparam logic [MODE_W-1:0] CODE_WAKEUP   = 3'd1;
  localparam logic [MODE_W-1:0] CODE_READY    = 3'd2;
  localparam logic [MODE_W-1:0] CODE_TURBO    = 3'd3;
  localparam logic [MODE_W-1:0] CODE_ECO      = 3'd4;
  localparam logic [MODE_W-1:0] CODE_SURVIVAL = 3'd5;
  localparam logic [MODE_W-1:0] CODE_SLEEP    = 3'd6;
  localparam logic [MODE_W-1:0] CODE_ILLEGAL  = 3'd7;

  // motor commands
  localparam logic [MOTOR_W-1:0] MOTOR_STOP = 2'd0;
  localparam logic [MOTOR_W-1:0] MOTOR_ECO  = 2'd1;
  localparam logic [MOTOR_W-1:0] MOTOR_FULL = 2'd2;
  localparam logic [MOTOR_W-1:0] MOTOR_NONE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_WAKE_THR     = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_TURBO_THR    = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_ECO_THR      = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_SURVIVAL_THR = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_TURBO_FLASH  = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_ECO_BLINK    = 3'd5;
  localparam logic [CFG_A_W-1:0] CFG_BREATH_STEP  = 3'd6;

  // configuration reset values
  localparam logic [VOLT_W-1:0] RST_WAKE_THR     = 14'd4000;
  localparam logic [VOLT_W-1:0] RST_TURBO_THR    = 14'd3000;
  localparam logic [VOLT_W-1:0] RST_ECO_THR      = 14'd2000;
  localparam logic [VOLT_W-1:0] RST_SURVIVAL_THR = 14'd1000;
  localparam logic [IVAL_W-1:0] RST_TURBO_FLASH  = 16'd200;
  localparam logic [IVAL_W-1:0] RST_ECO_BLINK    = 16'd500;
  localparam logic [IVAL_W-1:0] RST_BREATH_STEP  = 16'd50;

  // breathing ramp
  localparam logic [LEVEL_W-1:0] BREATH_TOP  = 7'd125;
  localparam logic [LEVEL_W-1:0] BREATH_LOW  = 7'd10;
  localparam logic [LEVEL_W-1:0] BREATH_STEP = 7'd20;
  localparam logic [LEVEL_W-1:0] BREATH_RISE_LIMIT = BREATH_TOP - BREATH_STEP;
  localparam logic [LEVEL_W-1:0] BREATH_FALL_LIMIT = BREATH_LOW + BREATH_STEP;

  localparam logic [LED_W-1:0] LED_FULL  = 8'd255;
  localparam logic [LED_W-1:0] LED_AMBER = 8'd165;
  localparam logic [LED_W-1:0] LED_OFF   = 8'd0;

  typedef struct packed {
    logic [VOLT_W-1:0] wake_thr;
    logic [VOLT_W-1:0] turbo_thr;
    logic [VOLT_W-1:0] eco_thr;
    logic [VOLT_W-1:0] survival_thr;
    logic [IVAL_W-1:0] turbo_flash;
    logic [IVAL_W-1:0] eco_blink;
    logic [IVAL_W-1:0] breath_step;
  } cfg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_mv;
    logic              charge_done;
    logic              lever_pressed;
    logic [TIME_W-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [MODE_W-1:0]  energy_mode;
    logic [MOTOR_W-1:0] motor_cmd;
    logic [LED_W-1:0]   led_red;
    logic [LED_W-1:0]   led_green;
    logic [LED_W-1:0]   led_blue;
    logic               led_write;
    logic               sleep_request;
  } result_t;

  // wrapped time difference against an interval
  function automatic logic elapsed(input logic [TIME_W-1:0] now_t,
                                   input logic [TIME_W-1:0] then_t,
                                   input logic [IVAL_W-1:0] ival);
    logic [TIME_W-1:0] diff;
    diff = now_t - then_t;
    return diff >= TIME_W'(ival);
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_CHARGING: c = CODE_CHARGING;
      MODE_WAKEUP:   c = CODE_WAKEUP;
      MODE_READY:    c = CODE_READY;
      MODE_TURBO:    c = CODE_TURBO;
      MODE_ECO:      c = CODE_ECO;
      MODE_SURVIVAL: c = CODE_SURVIVAL;
      MODE_SLEEP:    c = CODE_SLEEP;
      default:       c = CODE_ILLEGAL;
    endcase
    return c;
  endfunction

endpackage

// File: src/secmc_cfg.sv
module secmc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [secmc_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [secmc_pkg::CFG_D_W-1:0]    cfg_data,
  output secmc_pkg::cfg_t                  cfg
);

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_thr     <= secmc_pkg::RST_WAKE_THR;
      cfg.turbo_thr    <= secmc_pkg::RST_TURBO_THR;
      cfg.eco_thr      <= secmc_pkg::RST_ECO_THR;
      cfg.survival_thr <= secmc_pkg::RST_SURVIVAL_THR;
      cfg.turbo_flash  <= secmc_pkg::RST_TURBO_FLASH;
      cfg.eco_blink    <= secmc_pkg::RST_ECO_BLINK;
      cfg.breath_step  <= secmc_pkg::RST_BREATH_STEP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        secmc_pkg::CFG_WAKE_THR:
          cfg.wake_thr <= cfg_data[secmc_pkg::VOLT_W-1:0];
        secmc_pkg::CFG_TURBO_THR:
          cfg.turbo_thr <= cfg_data[secmc_pkg::VOLT_W-1:0];
        secmc_pkg::CFG_ECO_THR:
          cfg.eco_thr <= cfg_data[secmc_pkg::VOLT_W-1:0];
        secmc_pkg::CFG_SURVIVAL_THR:
          cfg.survival_thr <= cfg_data[secmc_pkg::VOLT_W-1:0];
        secmc_pkg::CFG_TURBO_FLASH:
          cfg.turbo_flash <= cfg_data[secmc_pkg::IVAL_W-1:0];
        secmc_pkg::CFG_ECO_BLINK:
          cfg.eco_blink <= cfg_data[secmc_pkg::IVAL_W-1:0];
        secmc_pkg::CFG_BREATH_STEP:
          cfg.breath_step <= cfg_data[secmc_pkg::IVAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/secmc_step.sv
module secmc_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  secmc_pkg::tick_t     tick,
  input  secmc_pkg::cfg_t      cfg,
  output secmc_pkg::result_t   res
);

  secmc_pkg::mode_t                   mode, mode_next;
  logic                               turbo_entered, turbo_entered_next;
  logic                               flash_phase, flash_phase_next;
  logic [secmc_pkg::TIME_W-1:0]       flash_time, flash_time_next;
  logic                               blink_phase, blink_phase_next;
  logic [secmc_pkg::TIME_W-1:0]       blink_time, blink_time_next;
  logic [secmc_pkg::LEVEL_W-1:0]      breath_level, breath_level_next;
  logic                               breath_rising, breath_rising_next;
  logic [secmc_pkg::TIME_W-1:0]       breath_time, breath_time_next;

  logic                               flash_phase_eff;
  logic [secmc_pkg::TIME_W-1:0]       flash_time_eff;
  logic                               volt_above_wake;

  // flash timer restarts on the first turbo tick
  assign flash_phase_eff = turbo_entered ? flash_phase : 1'b0;
  assign flash_time_eff  = turbo_entered ? flash_time : tick.now_ms;
  assign volt_above_wake = tick.voltage_mv > cfg.wake_thr;

  // next state and actions, following the mode held before the tick
  always_comb begin
    mode_next          = mode;
    turbo_entered_next = turbo_entered;
    flash_phase_next   = flash_phase;
    flash_time_next    = flash_time;
    blink_phase_next   = blink_phase;
    blink_time_next    = blink_time;
    breath_level_next  = breath_level;
    breath_rising_next = breath_rising;
    breath_time_next   = breath_time;
    res.motor_cmd      = secmc_pkg::MOTOR_NONE;
    res.led_red        = secmc_pkg::LED_OFF;
    res.led_green      = secmc_pkg::LED_OFF;
    res.led_blue       = secmc_pkg::LED_OFF;
    res.led_write      = 1'b0;
    res.sleep_request  = 1'b0;

    unique case (mode)
      secmc_pkg::MODE_CHARGING: begin
        if (volt_above_wake) mode_next = secmc_pkg::MODE_WAKEUP;
        res.motor_cmd = secmc_pkg::MOTOR_STOP;
        res.led_red   = secmc_pkg::LED_FULL;
        res.led_write = 1'b1;
      end
      secmc_pkg::MODE_WAKEUP: begin
        if (tick.lever_pressed) mode_next = secmc_pkg::MODE_TURBO;
        else if (tick.charge_done) mode_next = secmc_pkg::MODE_READY;
        res.led_red   = secmc_pkg::LED_FULL;
        res.led_green = secmc_pkg::LED_AMBER;
        res.led_write = 1'b1;
      end
      secmc_pkg::MODE_READY: begin
        if (tick.lever_pressed) mode_next = secmc_pkg::MODE_TURBO;
        res.led_green = secmc_pkg::LED_FULL;
        res.led_write = 1'b1;
      end
      secmc_pkg::MODE_TURBO: begin
        if (tick.voltage_mv < cfg.turbo_thr) mode_next = secmc_pkg::MODE_ECO;
        res.motor_cmd      = secmc_pkg::MOTOR_ECO;
        turbo_entered_next = 1'b1;
        flash_phase_next   = flash_phase_eff;
        flash_time_next    = flash_time_eff;
        if (secmc_pkg::elapsed(tick.now_ms, flash_time_eff, cfg.turbo_flash)) begin
          flash_phase_next = ~flash_phase_eff;
          flash_time_next  = tick.now_ms;
        end
        if (flash_phase_next) res.led_red = secmc_pkg::LED_FULL;
        else res.led_blue = secmc_pkg::LED_FULL;
        res.led_write = 1'b1;
      end
      secmc_pkg::MODE_ECO: begin
        if (tick.voltage_mv < cfg.eco_thr) mode_next = secmc_pkg::MODE_SURVIVAL;
        res.motor_cmd      = secmc_pkg::MOTOR_FULL;
        turbo_entered_next = 1'b0;
        if (secmc_pkg::elapsed(tick.now_ms, blink_time, cfg.eco_blink)) begin
          blink_phase_next = ~blink_phase;
          blink_time_next  = tick.now_ms;
        end
        if (blink_phase_next) begin
          res.led_red   = secmc_pkg::LED_FULL;
          res.led_green = secmc_pkg::LED_FULL;
        end
        res.led_write = 1'b1;
      end
      secmc_pkg::MODE_SURVIVAL: begin
        if (tick.voltage_mv < cfg.survival_thr) mode_next = secmc_pkg::MODE_SLEEP;
        res.motor_cmd      = secmc_pkg::MOTOR_FULL;
        turbo_entered_next = 1'b0;
        // breathing ramp bounces between floor and ceiling
        if (secmc_pkg::elapsed(tick.now_ms, breath_time, cfg.breath_step)) begin
          breath_time_next = tick.now_ms;
          if (breath_rising) begin
            if (breath_level >= secmc_pkg::BREATH_RISE_LIMIT) begin
              breath_level_next  = secmc_pkg::BREATH_TOP;
              breath_rising_next = 1'b0;
            end else begin
              breath_level_next = breath_level + secmc_pkg::BREATH_STEP;
            end
          end else begin
            if (breath_level <= secmc_pkg::BREATH_FALL_LIMIT) begin
              breath_level_next  = secmc_pkg::BREATH_LOW;
              breath_rising_next = 1'b1;
            end else begin
              breath_level_next = breath_level - secmc_pkg::BREATH_STEP;
            end
          end
          res.led_red   = {1'b0, breath_level_next};
          res.led_write = 1'b1;
        end
      end
      secmc_pkg::MODE_SLEEP: begin
        if (volt_above_wake) mode_next = secmc_pkg::MODE_WAKEUP;
        res.motor_cmd     = secmc_pkg::MOTOR_STOP;
        res.led_write     = 1'b1;
        res.sleep_request = 1'b1;
      end
      default: ;
    endcase

    res.energy_mode = secmc_pkg::mode_code(mode_next);
  end

  // controller state, updated once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= secmc_pkg::MODE_CHARGING;
      turbo_entered <= 1'b0;
      flash_phase   <= 1'b0;
      flash_time    <= '0;
      blink_phase   <= 1'b0;
      blink_time    <= '0;
      breath_level  <= '0;
      breath_rising <= 1'b1;
      breath_time   <= '0;
    end else if (en) begin
      mode          <= mode_next;
      turbo_entered <= turbo_entered_next;
      flash_phase   <= flash_phase_next;
      flash_time    <= flash_time_next;
      blink_phase   <= blink_phase_next;
      blink_time    <= blink_time_next;
      breath_level  <= breath_level_next;
      breath_rising <= breath_rising_next;
      breath_time   <= breath_time_next;
    end
  end

endmodule

// File: src/supercap_energy_mode_controller.sv
// Supercapacitor energy mode controller. Each input transaction is one control
// tick (voltage, charge-done, lever, millisecond time) and gives exactly one
// output transaction: the new energy mode, a motor command, RGB LED levels with
// a write strobe and a sleep request. A tick is captured in an input register,
// evaluated against the mode state combinationally and lands in an output
// register. A new tick is taken every cycle while the output side keeps up;
// when the output is stalled, one further tick is held in the input register.
// The user must write thresholds and intervals through the cfg port only while
// no tick is in flight (the block itself does not enforce this); they take
// effect on the next tick; indexes beyond the register list are ignored.
module supercap_energy_mode_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [secmc_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [secmc_pkg::CFG_D_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [secmc_pkg::VOLT_W-1:0]       voltage_mv,
  input  logic                               charge_done,
  input  logic                               lever_pressed,
  input  logic [secmc_pkg::TIME_W-1:0]       now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [secmc_pkg::MODE_W-1:0]       energy_mode,
  output logic [secmc_pkg::MOTOR_W-1:0]      motor_cmd,
  output logic [secmc_pkg::LED_W-1:0]        led_red,
  output logic [secmc_pkg::LED_W-1:0]        led_green,
  output logic [secmc_pkg::LED_W-1:0]        led_blue,
  output logic                               led_write,
  output logic                               sleep_request
);

  secmc_pkg::cfg_t     cfg;
  secmc_pkg::tick_t    tick;
  secmc_pkg::result_t  res;
  logic                tick_valid;
  logic                advance;

  secmc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // tick moves on when the output register is free or being emptied
  assign advance  = tick_valid && (!out_valid || !out_stall);
  assign in_stall = tick_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick.voltage_mv    <= voltage_mv;
      tick.charge_done   <= charge_done;
      tick.lever_pressed <= lever_pressed;
      tick.now_ms        <= now_ms;
    end
  end

  secmc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .tick (tick),
    .cfg  (cfg),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      energy_mode   <= res.energy_mode;
      motor_cmd     <= res.motor_cmd;
      led_red       <= res.led_red;
      led_green     <= res.led_green;
      led_blue      <= res.led_blue;
      led_write     <= res.led_write;
      sleep_request <= res.sleep_request;
    end
  end

endmodule

// File: bench/energy_mode_check_pkg.sv
package energy_mode_check_pkg;
  import secmc_pkg::*;

  // works out the controller's response to each tick and checks what comes out
  class energy_mode_scoreboard;
    // copies of the threshold and interval registers
    logic [VOLT_W-1:0] wake_thr;
    logic [VOLT_W-1:0] turbo_thr;
    logic [VOLT_W-1:0] eco_thr;
    logic [VOLT_W-1:0] survival_thr;
    logic [IVAL_W-1:0] flash_ms;
    logic [IVAL_W-1:0] blink_ms;
    logic [IVAL_W-1:0] breath_ms;

    // controller state
    logic [MODE_W-1:0] mode;
    logic              turbo_entered;
    logic              flash_phase;
    logic              blink_phase;
    logic              breath_rising;
    logic [TIME_W-1:0] flash_time;
    logic [TIME_W-1:0] blink_time;
    logic [TIME_W-1:0] breath_time;
    int                breath_level;

    result_t predicted_results[$];
    int      mismatches;
    int      results_seen;

    function new();
      wake_thr      = RST_WAKE_THR;
      turbo_thr     = RST_TURBO_THR;
      eco_thr       = RST_ECO_THR;
      survival_thr  = RST_SURVIVAL_THR;
      flash_ms      = RST_TURBO_FLASH;
      blink_ms      = RST_ECO_BLINK;
      breath_ms     = RST_BREATH_STEP;
      mode          = CODE_CHARGING;
      turbo_entered = 1'b0;
      flash_phase   = 1'b0;
      blink_phase   = 1'b0;
      breath_rising = 1'b1;
      flash_time    = '0;
      blink_time    = '0;
      breath_time   = '0;
      breath_level  = 0;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    // register write; thresholds keep their low 14 bits, unknown indexes do nothing
    function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
      case (idx)
        CFG_WAKE_THR:     wake_thr = data[VOLT_W-1:0];
        CFG_TURBO_THR:    turbo_thr = data[VOLT_W-1:0];
        CFG_ECO_THR:      eco_thr = data[VOLT_W-1:0];
        CFG_SURVIVAL_THR: survival_thr = data[VOLT_W-1:0];
        CFG_TURBO_FLASH:  flash_ms = data[IVAL_W-1:0];
        CFG_ECO_BLINK:    blink_ms = data[IVAL_W-1:0];
        CFG_BREATH_STEP:  breath_ms = data[IVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction

    // one accepted tick: actions follow the mode held before the transition
    function void accept_tick(tick_t t);
      result_t           r;
      logic [MODE_W-1:0] nxt;
      logic [TIME_W-1:0] gone;
      r = '0;
      r.motor_cmd = MOTOR_NONE;
      nxt = mode;
      case (mode)
        CODE_CHARGING: begin
          if (t.voltage_mv > wake_thr) nxt = CODE_WAKEUP;
          r.motor_cmd = MOTOR_STOP;
          r.led_red = LED_FULL;
          r.led_write = 1'b1;
        end
        CODE_WAKEUP: begin
          if (t.charge_done) nxt = CODE_READY;
          if (t.lever_pressed) nxt = CODE_TURBO;
          r.led_red = LED_FULL;
          r.led_green = LED_AMBER;
          r.led_write = 1'b1;
        end
        CODE_READY: begin
          if (t.lever_pressed) nxt = CODE_TURBO;
          r.led_green = LED_FULL;
          r.led_write = 1'b1;
        end
        CODE_TURBO: begin
          if (t.voltage_mv < turbo_thr) nxt = CODE_ECO;
          r.motor_cmd = MOTOR_ECO;
          // first tick in turbo restarts the flash timer
          if (!turbo_entered) begin
            flash_time = t.now_ms;
            flash_phase = 1'b0;
            turbo_entered = 1'b1;
          end
          gone = t.now_ms - flash_time;
          if (gone >= TIME_W'(flash_ms)) begin
            flash_phase = !flash_phase;
            flash_time = t.now_ms;
          end
          if (flash_phase) r.led_red = LED_FULL;
          else r.led_blue = LED_FULL;
          r.led_write = 1'b1;
        end
        CODE_ECO: begin
          if (t.voltage_mv < eco_thr) nxt = CODE_SURVIVAL;
          r.motor_cmd = MOTOR_FULL;
          turbo_entered = 1'b0;
          gone = t.now_ms - blink_time;
          if (gone >= TIME_W'(blink_ms)) begin
            blink_phase = !blink_phase;
            blink_time = t.now_ms;
          end
          if (blink_phase) begin
            r.led_red = LED_FULL;
            r.led_green = LED_FULL;
          end
          r.led_write = 1'b1;
        end
        CODE_SURVIVAL: begin
          if (t.voltage_mv < survival_thr) nxt = CODE_SLEEP;
          r.motor_cmd = MOTOR_FULL;
          turbo_entered = 1'b0;
          // breathing ramp, LED only written on a step
          gone = t.now_ms - breath_time;
          if (gone >= TIME_W'(breath_ms)) begin
            breath_time = t.now_ms;
            if (breath_rising) begin
              breath_level += int'(BREATH_STEP);
              if (breath_level >= int'(BREATH_TOP)) begin
                breath_level = int'(BREATH_TOP);
                breath_rising = 1'b0;
              end
            end else begin
              breath_level -= int'(BREATH_STEP);
              if (breath_level <= int'(BREATH_LOW)) begin
                breath_level = int'(BREATH_LOW);
                breath_rising = 1'b1;
              end
            end
            r.led_red = LED_W'(breath_level);
            r.led_write = 1'b1;
          end
        end
        CODE_SLEEP: begin
          r.motor_cmd = MOTOR_STOP;
          r.led_write = 1'b1;
          r.sleep_request = 1'b1;
          if (t.voltage_mv > wake_thr) nxt = CODE_WAKEUP;
        end
        default: ;
      endcase
      mode = nxt;
      r.energy_mode = nxt;
      predicted_results.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // one accepted result against the oldest prediction
    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (predicted_results.size() == 0) begin
        report("result with no tick awaiting it");
        return;
      end
      want = predicted_results.pop_front();
      compare_field("energy_mode", 32'(got.energy_mode), 32'(want.energy_mode));
      compare_field("motor_cmd", 32'(got.motor_cmd), 32'(want.motor_cmd));
      compare_field("led_red", 32'(got.led_red), 32'(want.led_red));
      compare_field("led_green", 32'(got.led_green), 32'(want.led_green));
      compare_field("led_blue", 32'(got.led_blue), 32'(want.led_blue));
      compare_field("led_write", 32'(got.led_write), 32'(want.led_write));
      compare_field("sleep_request", 32'(got.sleep_request), 32'(want.sleep_request));
    endtask
  endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import secmc_pkg::*;
  import energy_mode_check_pkg::*;

  localparam logic [CFG_A_W-1:0] CFG_NO_REG = 3'd7;
  localparam int LONG_HOLD   = 150;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_TICKS = 185;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VOLT_W-1:0]  voltage_mv = '0;
  logic               charge_done = 1'b0;
  logic               lever_pressed = 1'b0;
  logic [TIME_W-1:0]  now_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [MODE_W-1:0]  energy_mode;
  logic [MOTOR_W-1:0] motor_cmd;
  logic [LED_W-1:0]   led_red;
  logic [LED_W-1:0]   led_green;
  logic [LED_W-1:0]   led_blue;
  logic               led_write;
  logic               sleep_request;

  energy_mode_scoreboard sb;
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  int                    hold_serial = 0;
  int                    ticks_sent = 0;
  logic [TIME_W-1:0]     clock_ms = '0;

  supercap_energy_mode_controller DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .voltage_mv(voltage_mv),
    .charge_done(charge_done),
    .lever_pressed(lever_pressed),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .energy_mode(energy_mode),
    .motor_cmd(motor_cmd),
    .led_red(led_red),
    .led_green(led_green),
    .led_blue(led_blue),
    .led_write(led_write),
    .sleep_request(sleep_request)
  );

  always #6 clk = ~clk;

  // idle length: none unless drawn with the given percentage; then mostly short, now and then long
  function automatic int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // offer one tick and hold it until the block takes it
  task automatic send_tick(input logic [VOLT_W-1:0] v, input logic done,
                           input logic lever, input logic [TIME_W-1:0] t);
    int    gap;
    tick_t item;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.voltage_mv = v;
    item.charge_done = done;
    item.lever_pressed = lever;
    item.now_ms = t;
    in_valid <= 1'b1;
    voltage_mv <= v;
    charge_done <= done;
    lever_pressed <= lever;
    now_ms <= t;
    do @(posedge clk); while (in_stall);
    sb.accept_tick(item);
    ticks_sent++;
  endtask

  // advance the millisecond time on the scale of the current intervals, then send
  task automatic next_tick(input int v, input logic done, input logic lever);
    int lo;
    int hi;
    lo = int'(sb.flash_ms);
    hi = int'(sb.flash_ms);
    if (int'(sb.blink_ms) < lo) lo = int'(sb.blink_ms);
    if (int'(sb.breath_ms) < lo) lo = int'(sb.breath_ms);
    if (int'(sb.blink_ms) > hi) hi = int'(sb.blink_ms);
    if (int'(sb.breath_ms) > hi) hi = int'(sb.breath_ms);
    if ($urandom_range(19) == 0) clock_ms = $urandom;
    else if ($urandom_range(1) == 0) clock_ms += $urandom_range(2 * lo + 1, 0);
    else clock_ms += $urandom_range(hi + 1, 0);
    send_tick(VOLT_W'(v), done, lever, clock_ms);
  endtask

  // stop offering and wait for every predicted result
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // new thresholds and intervals once the block is idle
  task automatic load_settings(input logic [CFG_D_W-1:0] wake, input logic [CFG_D_W-1:0] turbo,
                               input logic [CFG_D_W-1:0] eco, input logic [CFG_D_W-1:0] surv,
                               input logic [CFG_D_W-1:0] flash, input logic [CFG_D_W-1:0] blink,
                               input logic [CFG_D_W-1:0] breath);
    settle();
    write_reg(CFG_NO_REG, CFG_D_W'($urandom));
    write_reg(CFG_WAKE_THR, wake);
    write_reg(CFG_TURBO_THR, turbo);
    write_reg(CFG_ECO_THR, eco);
    write_reg(CFG_SURVIVAL_THR, surv);
    write_reg(CFG_TURBO_FLASH, flash);
    write_reg(CFG_ECO_BLINK, blink);
    write_reg(CFG_BREATH_STEP, breath);
    cfg_we <= 1'b0;
  endtask

  // discharge cycles: charge up past wake, linger for the lever, then drain to empty
  task automatic run_random(input int n);
    int target;
    int top;
    int v;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      if ($urandom_range(99) < 15) begin
        // stray tick with every field random
        clock_ms = $urandom;
        send_tick(VOLT_W'($urandom), 1'($urandom), 1'($urandom), clock_ms);
      end else begin
        top = $urandom_range(16383, 32'(sb.wake_thr));
        repeat ($urandom_range(8, 2))
          next_tick(top, $urandom_range(2) == 0, $urandom_range(2) == 0);
        v = top;
        while (v > 0) begin
          v -= $urandom_range(top / 8 + 1, 1);
          if (v < 0) v = 0;
          next_tick(v, $urandom_range(2) == 0, $urandom_range(2) == 0);
        end
        repeat ($urandom_range(3, 1))
          next_tick($urandom_range(32'(sb.survival_thr), 0), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int      stall_left;
    int      seen_hold;
    result_t got;
    stall_left = 0;
    seen_hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.energy_mode = energy_mode;
        got.motor_cmd = motor_cmd;
        got.led_red = led_red;
        got.led_green = led_green;
        got.led_blue = led_blue;
        got.led_write = led_write;
        got.sleep_request = sleep_request;
        sb.check_result(got);
      end
      if (hold_serial != seen_hold) begin
        seen_hold = hold_serial;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = idle_len(stall_pct);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int s;
    int e;
    int tu;
    int w;
    sb = new();
    gap_pct = 30;
    stall_pct = 30;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed walk through every mode on the reset settings
    send_tick(14'd0, 1'b0, 1'b0, 32'd0);
    send_tick(14'd4000, 1'b0, 1'b0, 32'd5);        // on the wake threshold: no change
    send_tick(14'd4001, 1'b0, 1'b0, 32'd10);       // wakes up
    send_tick(14'd16383, 1'b0, 1'b0, 32'd20);
    send_tick(14'd16383, 1'b1, 1'b0, 32'd30);      // charge done: ready
    send_tick(14'd16383, 1'b1, 1'b0, 32'd40);
    send_tick(14'd16383, 1'b0, 1'b1, 32'd50);      // lever: turbo
    send_tick(14'd3000, 1'b0, 1'b0, 32'd1000);     // first turbo tick, on the threshold
    send_tick(14'd16383, 1'b0, 1'b0, 32'd1199);    // just short of the flash interval
    send_tick(14'd16383, 1'b0, 1'b0, 32'd1200);    // flash toggles
    send_tick(14'd2999, 1'b0, 1'b0, 32'hFFFF_FFFF); // time far ahead, drop to eco
    send_tick(14'd2000, 1'b0, 1'b0, 32'd499);      // time wraps back, blink not due
    send_tick(14'd1999, 1'b0, 1'b0, 32'd500);      // blink on, drop to survival
    send_tick(14'd1000, 1'b0, 1'b0, 32'd550);
    send_tick(14'd1000, 1'b0, 1'b0, 32'd599);      // no breath step, no LED write
    // breathing up to the ceiling, down to the floor and up again
    for (int k = 1; k <= 14; k++) send_tick(14'd1000, 1'b0, 1'b0, 32'(550 + 50 * k));
    send_tick(14'd999, 1'b0, 1'b0, 32'd1300);      // drop to sleep
    send_tick(14'd4000, 1'b0, 1'b0, 32'd1400);
    send_tick(14'd4001, 1'b0, 1'b0, 32'd1500);     // sleep wakes up
    send_tick(14'd100, 1'b1, 1'b1, 32'd1600);      // lever beats charge done
    send_tick(14'd0, 1'b0, 1'b0, 32'd1700);        // turbo entered afresh, falls to eco
    clock_ms = 32'd2000;

    // reset settings with a long hold-off part way through
    run_random(PHASE_TICKS / 2);
    gap_pct = 0;
    hold_serial <= hold_serial + 1;
    repeat (24) next_tick($urandom_range(16383), 1'($urandom_range(1)), 1'($urandom_range(1)));
    gap_pct = 30;
    settle();
    run_random(PHASE_TICKS / 2);

    // everything drops at once, zero intervals, no idling on either side
    load_settings(16'd0, 16'h3FFF, 16'h3FFF, 16'h3FFF, 16'd0, 16'd0, 16'd0);
    gap_pct = 0;
    stall_pct = 0;
    run_random(PHASE_TICKS);

    // turbo never drops, longest intervals, heavy idling
    load_settings(16'd16382, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gap_pct = 50;
    stall_pct = 50;
    run_random(PHASE_TICKS);

    // ordered random thresholds, short random intervals
    s = $urandom_range(4000, 0);
    e = s + $urandom_range(4000, 0);
    tu = e + $urandom_range(4000, 0);
    w = tu + $urandom_range(4000, 0);
    load_settings(CFG_D_W'(w), CFG_D_W'(tu), CFG_D_W'(e), CFG_D_W'(s),
                  CFG_D_W'($urandom_range(300, 1)), CFG_D_W'($urandom_range(300, 1)),
                  CFG_D_W'($urandom_range(300, 1)));
    gap_pct = 20;
    stall_pct = 60;
    run_random(PHASE_TICKS);

    // full random register contents
    load_settings(CFG_D_W'($urandom), CFG_D_W'($urandom), CFG_D_W'($urandom),
                  CFG_D_W'($urandom), CFG_D_W'($urandom), CFG_D_W'($urandom),
                  CFG_D_W'($urandom));
    gap_pct = 40;
    stall_pct = 20;
    run_random(PHASE_TICKS);

    // mid thresholds with single millisecond intervals
    load_settings(16'd3000, 16'd2500, 16'd1500, 16'd500, 16'd1, 16'd1, 16'd1);
    gap_pct = 10;
    stall_pct = 10;
    run_random(PHASE_TICKS);

    // drain and finish
    settle();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
